[sv/tpfa_pkg.sv]
// Shared constants, codes and types of the thermal packet frame assembler.
`timescale 1ns / 1ps
`default_nettype none
package tpfa_pkg;

   localparam int PACKET_BYTES_DEF        = 164;
   localparam int PACKETS_PER_SEGMENT_DEF = 60;
   localparam int PIXELS_PER_PACKET_DEF   = 80;
   localparam int SEGMENTS_DEF            = 4;
   localparam int QUEUE_DEPTH_DEF         = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0]  REG_TIMEOUT   = 1'b0;
   localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_FAIL = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   localparam logic [7:0]  POS_ID          = 8'd0;
   localparam logic [7:0]  POS_NUMBER      = 8'd1;
   localparam logic [7:0]  POS_FIRST_PIXEL = 8'd4;
   localparam logic [7:0]  SEG_SET_PACKET  = 8'd20;
   localparam logic [3:0]  DROP_ID_NIBBLE  = 4'hF;
   localparam logic [15:0] DISCARD_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_FAIL,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] rx_byte;
      logic       packet_start;
   } work_type;

   typedef struct packed {
      logic     push;
      work_type work;
   } queue_in_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } queue_out_type;

   typedef struct packed {
      logic        pixel_write;
      logic [14:0] pixel_index;
      logic [15:0] pixel_value;
      logic        frame_done;
      logic        frame_failed;
      logic [15:0] discard_count;
   } result_type;

endpackage
`default_nettype wire

[sv/tpfa_if.sv]
// Word channel interfaces for the packet input and the pixel result output.
`timescale 1ns / 1ps
`default_nettype none
interface tpfa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;
   logic       packet_start;

   modport source (output valid, action, rx_byte, packet_start, input ready);
   modport sink (input valid, action, rx_byte, packet_start, output ready);
endinterface

interface tpfa_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_write;
   logic [14:0] pixel_index;
   logic [15:0] pixel_value;
   logic        frame_done;
   logic        frame_failed;
   logic [15:0] discard_count;

   modport source (output valid, pixel_write, pixel_index, pixel_value, frame_done,
                   frame_failed, discard_count, input ready);
   modport sink (input valid, pixel_write, pixel_index, pixel_value, frame_done,
                 frame_failed, discard_count, output ready);
endinterface
`default_nettype wire

[sv/tpfa_front.sv]
// Front end: accepts input words, decodes the action and pushes work into the queue.
`timescale 1ns / 1ps
`default_nettype none
module tpfa_front (
   tpfa_req_if.sink              req_chan,
   input  logic                  queue_full,
   output tpfa_pkg::queue_in_type queue_in
);

   logic keep;

   assign req_chan.ready = !queue_full;

   always_comb begin
      keep = 1'b1;
      queue_in.work.rx_byte      = req_chan.rx_byte;
      queue_in.work.packet_start = req_chan.packet_start;
      unique case (req_chan.action)
         tpfa_pkg::ACT_BYTE: queue_in.work.op = tpfa_pkg::OP_BYTE;
         tpfa_pkg::ACT_FAIL: queue_in.work.op = tpfa_pkg::OP_FAIL;
         tpfa_pkg::ACT_TICK: queue_in.work.op = tpfa_pkg::OP_TICK;
         default: begin
            queue_in.work.op = tpfa_pkg::OP_BYTE;
            keep = 1'b0;
         end
      endcase
      queue_in.push = req_chan.valid && req_chan.ready && keep;
   end

endmodule
`default_nettype wire

[sv/tpfa_queue.sv]
// Short work queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tpfa_queue #(
   parameter int DEPTH = tpfa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpfa_pkg::queue_in_type  queue_in,
   input  logic                    pop,
   output logic                    full,
   output tpfa_pkg::queue_out_type queue_out
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   tpfa_pkg::work_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full            = (count_ff == FULL_COUNT);
   assign queue_out.valid = (count_ff != '0);
   assign queue_out.work  = entries_ff[rd_ptr_ff];
   assign do_push         = queue_in.push && !full;
   assign do_pop          = pop && queue_out.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= queue_in.work;
      end
   end

endmodule
`default_nettype wire

[sv/tpfa_back.sv]
// Back end: packet parsing, segment tracking, capture timer and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tpfa_back #(
   parameter int PACKET_BYTES        = tpfa_pkg::PACKET_BYTES_DEF,
   parameter int PACKETS_PER_SEGMENT = tpfa_pkg::PACKETS_PER_SEGMENT_DEF,
   parameter int PIXELS_PER_PACKET   = tpfa_pkg::PIXELS_PER_PACKET_DEF,
   parameter int SEGMENTS            = tpfa_pkg::SEGMENTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             timeout_ms,
   input  tpfa_pkg::queue_out_type queue_out,
   output logic                    pop,
   tpfa_rsp_if.source              rsp_chan
);

   localparam logic [7:0]  PB        = 8'(PACKET_BYTES);
   localparam logic [7:0]  LAST_BYTE = 8'(PACKET_BYTES - 1);
   localparam logic [7:0]  PPS       = 8'(PACKETS_PER_SEGMENT);
   localparam logic [5:0]  LAST_PKT  = 6'(PACKETS_PER_SEGMENT - 1);
   localparam logic [6:0]  PIX7      = 7'(PIXELS_PER_PACKET);
   localparam logic [14:0] PIX15     = 15'(PIXELS_PER_PACKET);
   localparam logic [2:0]  SEG3      = 3'(SEGMENTS);
   localparam logic [14:0] SEG_PIX   = 15'((PACKETS_PER_SEGMENT * PIXELS_PER_PACKET) % 32768);

   logic [7:0]  byte_pos_ff, byte_pos_in;
   logic [2:0]  cur_seg_ff, cur_seg_in;
   logic        dropped_ff, dropped_in;
   logic [5:0]  pkt_num_ff, pkt_num_in;
   logic [2:0]  id_seg_ff, id_seg_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] discards_ff, discards_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [14:0] seg_base_ff, seg_base_in;
   logic [14:0] pkt_base_ff, pkt_base_in;
   logic        out_valid_ff, out_valid_in;
   tpfa_pkg::result_type out_ff, out_in;

   logic back_ready;

   assign back_ready = !out_valid_ff || rsp_chan.ready;
   assign pop        = queue_out.valid && back_ready;

   always_comb begin
      logic [7:0]  pos;
      logic [7:0]  pos_off;
      logic [6:0]  pix_num;
      logic [7:0]  b;
      logic [15:0] disc_inc;
      logic        emit;
      tpfa_pkg::result_type res;

      byte_pos_in = byte_pos_ff;
      cur_seg_in  = cur_seg_ff;
      dropped_in  = dropped_ff;
      pkt_num_in  = pkt_num_ff;
      id_seg_in   = id_seg_ff;
      held_in     = held_ff;
      discards_in = discards_ff;
      elapsed_in  = elapsed_ff;
      seg_base_in = seg_base_ff;
      pkt_base_in = pkt_base_ff;
      out_in      = out_ff;
      res         = '0;
      emit        = 1'b0;
      b           = queue_out.work.rx_byte;
      pos         = queue_out.work.packet_start ? tpfa_pkg::POS_ID : byte_pos_ff;
      pos_off     = pos - tpfa_pkg::POS_FIRST_PIXEL;
      pix_num     = pos_off[7:1];
      disc_inc    = (discards_ff == tpfa_pkg::DISCARD_MAX) ? discards_ff
                                                           : discards_ff + 16'd1;

      if (pop) begin
         unique case (queue_out.work.op)
            tpfa_pkg::OP_FAIL: begin
               discards_in = disc_inc;
               byte_pos_in = PB;
            end
            tpfa_pkg::OP_TICK: begin
               if (elapsed_ff >= timeout_ms) begin
                  emit              = 1'b1;
                  res.frame_failed  = 1'b1;
                  res.discard_count = discards_ff;
                  discards_in       = '0;
                  cur_seg_in        = '0;
                  elapsed_in        = '0;
                  byte_pos_in       = PB;
                  dropped_in        = 1'b0;
               end else begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
            end
            tpfa_pkg::OP_BYTE: begin
               if (queue_out.work.packet_start || byte_pos_ff < PB) begin
                  byte_pos_in = pos + 8'd1;
                  if (pos == tpfa_pkg::POS_ID) begin
                     id_seg_in  = b[6:4];
                     dropped_in = (b[3:0] == tpfa_pkg::DROP_ID_NIBBLE);
                     if (b[3:0] == tpfa_pkg::DROP_ID_NIBBLE) begin
                        discards_in = disc_inc;
                     end
                  end else if (!dropped_ff) begin
                     if (pos == tpfa_pkg::POS_NUMBER) begin
                        if (b >= PPS) begin
                           dropped_in  = 1'b1;
                           discards_in = disc_inc;
                        end else begin
                           pkt_num_in  = b[5:0];
                           pkt_base_in = PIX15 * {9'd0, b[5:0]};
                           if (b == tpfa_pkg::SEG_SET_PACKET && id_seg_ff != '0 &&
                               id_seg_ff <= SEG3) begin
                              cur_seg_in  = id_seg_ff;
                              seg_base_in = SEG_PIX * {12'd0, id_seg_ff - 3'd1};
                           end
                        end
                     end else begin
                        if (pos >= tpfa_pkg::POS_FIRST_PIXEL && cur_seg_ff != '0 &&
                            pix_num < PIX7) begin
                           if (!pos_off[0]) begin
                              held_in = b;
                           end else begin
                              emit            = 1'b1;
                              res.pixel_write = 1'b1;
                              res.pixel_index = seg_base_ff + pkt_base_ff + {8'd0, pix_num};
                              res.pixel_value = {b, held_ff};
                           end
                        end
                        if (pos == LAST_BYTE && cur_seg_ff != '0 && pkt_num_ff == LAST_PKT) begin
                           if (cur_seg_ff >= SEG3) begin
                              emit              = 1'b1;
                              res.frame_done    = 1'b1;
                              res.discard_count = discards_ff;
                              discards_in       = '0;
                              cur_seg_in        = '0;
                              elapsed_in        = '0;
                              byte_pos_in       = PB;
                              dropped_in        = 1'b0;
                           end else begin
                              cur_seg_in  = cur_seg_ff + 3'd1;
                              seg_base_in = seg_base_ff + SEG_PIX;
                           end
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (pop && emit) begin
         out_in = res;
      end
      out_valid_in = back_ready ? (pop && emit) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= PB;
         cur_seg_ff   <= '0;
         dropped_ff   <= 1'b0;
         pkt_num_ff   <= '0;
         id_seg_ff    <= '0;
         held_ff      <= '0;
         discards_ff  <= '0;
         elapsed_ff   <= '0;
         pkt_base_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         cur_seg_ff   <= cur_seg_in;
         dropped_ff   <= dropped_in;
         pkt_num_ff   <= pkt_num_in;
         id_seg_ff    <= id_seg_in;
         held_ff      <= held_in;
         discards_ff  <= discards_in;
         elapsed_ff   <= elapsed_in;
         pkt_base_ff  <= pkt_base_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_base_ff <= seg_base_in;
      out_ff      <= out_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_write   = out_ff.pixel_write;
   assign rsp_chan.pixel_index   = out_ff.pixel_index;
   assign rsp_chan.pixel_value   = out_ff.pixel_value;
   assign rsp_chan.frame_done    = out_ff.frame_done;
   assign rsp_chan.frame_failed  = out_ff.frame_failed;
   assign rsp_chan.discard_count = out_ff.discard_count;

   a_byte_pos_range: assert property (@(posedge clock) disable iff (reset)
      byte_pos_ff <= PB)
      else $error("Byte position beyond the packet length.");

   a_segment_range: assert property (@(posedge clock) disable iff (reset)
      cur_seg_ff <= SEG3)
      else $error("Current segment beyond the segment count.");

   a_result_not_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.pixel_write || out_ff.frame_done || out_ff.frame_failed))
      else $error("Result word carries neither pixel nor status.");

   a_failure_alone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_failed) |-> (!out_ff.pixel_write && !out_ff.frame_done))
      else $error("Failure word combined with pixel or frame completion.");

endmodule
`default_nettype wire

[sv/thermal_packet_frame_assembler_core.sv]
// Top level of the thermal packet frame assembler with its configuration register.
//
//   Port group   Direction  Handshake          Contents
//   req_chan     in         valid/ready        action, rx_byte, packet_start
//   rsp_chan     out        valid/ready        pixel word, frame done/failed, discards
//   csr_*        in/out     APB write/read     timeout_ms at byte address 0
//
// One input word is accepted per cycle unless the queue is full; at acceptance it goes into
// the work queue; the back end pops it and loads its result word into the result register.
// When no result stalls, the back end handles one word per cycle, the sustained rate.
// Reset is synchronous and active high; the timeout register resets to 3000.
// A stalled result holds the back end while the queue keeps accepting until it fills.
`timescale 1ns / 1ps
`default_nettype none
module thermal_packet_frame_assembler_core #(
   parameter int PACKET_BYTES        = tpfa_pkg::PACKET_BYTES_DEF,
   parameter int PACKETS_PER_SEGMENT = tpfa_pkg::PACKETS_PER_SEGMENT_DEF,
   parameter int PIXELS_PER_PACKET   = tpfa_pkg::PIXELS_PER_PACKET_DEF,
   parameter int SEGMENTS            = tpfa_pkg::SEGMENTS_DEF,
   parameter int QUEUE_DEPTH         = tpfa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tpfa_req_if.sink                        req_chan,
   tpfa_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tpfa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tpfa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tpfa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [15:0] timeout_ff, timeout_in;
   logic        reg_index;
   logic        queue_full;
   logic        pop;
   tpfa_pkg::queue_in_type  queue_in;
   tpfa_pkg::queue_out_type queue_out;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign csr_prdata = (reg_index == tpfa_pkg::REG_TIMEOUT)
                       ? {16'd0, timeout_ff} : '0;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          reg_index == tpfa_pkg::REG_TIMEOUT) begin
         timeout_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= tpfa_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   tpfa_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .queue_in   (queue_in)
   );

   tpfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .queue_in  (queue_in),
      .pop       (pop),
      .full      (queue_full),
      .queue_out (queue_out)
   );

   tpfa_back #(
      .PACKET_BYTES        (PACKET_BYTES),
      .PACKETS_PER_SEGMENT (PACKETS_PER_SEGMENT),
      .PIXELS_PER_PACKET   (PIXELS_PER_PACKET),
      .SEGMENTS            (SEGMENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .timeout_ms (timeout_ff),
      .queue_out  (queue_out),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

[tb/sv/tpfa_pixel_compare.sv]
// Monitor that predicts each result word of the frame assembler and compares it field by field.
`timescale 1ns / 1ps
module tpfa_pixel_compare (
   input  logic                            clock,
   input  logic                            reset,
   tpfa_req_if                             req_mon,
   tpfa_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tpfa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tpfa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [tpfa_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              mismatches,
   output int                              words_awaited,
   output int                              pixels_seen,
   output int                              frames_done,
   output int                              frames_failed
);
   import tpfa_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = CSR_ADDR_W'(4 * REG_TIMEOUT);
   localparam int PKT_BYTES = PACKET_BYTES_DEF;
   localparam int PKTS_PER_SEG = PACKETS_PER_SEGMENT_DEF;
   localparam int PIX_PER_PKT = PIXELS_PER_PACKET_DEF;
   localparam int SEG_COUNT = SEGMENTS_DEF;

   logic [15:0] timeout_setting;
   logic [7:0]  pos_in_packet;
   logic [2:0]  segment_now;
   logic        packet_skipped;
   logic [5:0]  number_now;
   logic [2:0]  id_segment;
   logic [7:0]  low_byte;
   logic [15:0] discard_tally;
   logic [15:0] ms_elapsed;
   result_type  awaited[$];

   function automatic void count_discard();
      if (discard_tally != DISCARD_MAX) begin
         discard_tally++;
      end
   endfunction

   function automatic void restart_capture();
      discard_tally = '0;
      segment_now = '0;
      ms_elapsed = '0;
      pos_in_packet = 8'(PKT_BYTES);
      packet_skipped = 1'b0;
   endfunction

   function automatic void clear_state();
      timeout_setting = TIMEOUT_RESET;
      restart_capture();
      number_now = '0;
      id_segment = '0;
      low_byte = '0;
   endfunction

   // Advances the predicted state by one input word; returns 1 when a result word follows.
   function automatic bit predict_word(input logic [1:0] act, input logic [7:0] b,
                                       input logic st, output result_type r);
      int pos;
      int slot;
      int idx;
      bit pix;
      bit done;
      r = '0;
      pix = 1'b0;
      done = 1'b0;
      if (act == ACT_FAIL) begin
         count_discard();
         pos_in_packet = 8'(PKT_BYTES);
         return 1'b0;
      end
      if (act == ACT_TICK) begin
         if (ms_elapsed >= timeout_setting) begin
            r.frame_failed = 1'b1;
            r.discard_count = discard_tally;
            restart_capture();
            return 1'b1;
         end
         ms_elapsed++;
         return 1'b0;
      end
      if (act != ACT_BYTE) begin
         return 1'b0;
      end
      if (st) begin
         pos = 0;
      end else if (pos_in_packet < PKT_BYTES) begin
         pos = pos_in_packet;
      end else begin
         return 1'b0;
      end
      pos_in_packet = 8'(pos + 1);
      if (pos == POS_ID) begin
         packet_skipped = 1'b0;
         id_segment = b[6:4];
         if (b[3:0] == DROP_ID_NIBBLE) begin
            packet_skipped = 1'b1;
            count_discard();
         end
         return 1'b0;
      end
      if (packet_skipped) begin
         return 1'b0;
      end
      if (pos == POS_NUMBER) begin
         if (b >= PKTS_PER_SEG) begin
            packet_skipped = 1'b1;
            count_discard();
            return 1'b0;
         end
         number_now = b[5:0];
         if (b == SEG_SET_PACKET && id_segment != 0 && id_segment <= SEG_COUNT) begin
            segment_now = id_segment;
         end
         return 1'b0;
      end
      if (pos >= POS_FIRST_PIXEL && segment_now != 0) begin
         slot = (pos - POS_FIRST_PIXEL) >> 1;
         if (slot < PIX_PER_PKT) begin
            if (((pos - POS_FIRST_PIXEL) & 1) == 0) begin
               low_byte = b;
            end else begin
               pix = 1'b1;
               idx = (int'(segment_now) - 1) * PKTS_PER_SEG * PIX_PER_PKT
                     + int'(number_now) * PIX_PER_PKT + slot;
               r.pixel_index = idx[14:0];
               r.pixel_value = {b, low_byte};
            end
         end
      end
      if (pos == PKT_BYTES - 1 && segment_now != 0 && number_now == PKTS_PER_SEG - 1) begin
         if (segment_now >= SEG_COUNT) begin
            done = 1'b1;
            r.discard_count = discard_tally;
            restart_capture();
         end else begin
            segment_now++;
         end
      end
      if (!pix && !done) begin
         return 1'b0;
      end
      r.pixel_write = pix;
      r.frame_done = done;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   task automatic compare_word(input result_type got);
      result_type want;
      if (awaited.size() == 0) begin
         report_mismatch("result word with nothing outstanding", 0, 1);
         return;
      end
      want = awaited.pop_front();
      if (got.pixel_write != want.pixel_write) begin
         report_mismatch("pixel_write", want.pixel_write, got.pixel_write);
      end
      if (got.pixel_index != want.pixel_index) begin
         report_mismatch("pixel_index", want.pixel_index, got.pixel_index);
      end
      if (got.pixel_value != want.pixel_value) begin
         report_mismatch("pixel_value", want.pixel_value, got.pixel_value);
      end
      if (got.frame_done != want.frame_done) begin
         report_mismatch("frame_done", want.frame_done, got.frame_done);
      end
      if (got.frame_failed != want.frame_failed) begin
         report_mismatch("frame_failed", want.frame_failed, got.frame_failed);
      end
      if (got.discard_count != want.discard_count) begin
         report_mismatch("discard_count", want.discard_count, got.discard_count);
      end
   endtask

   always @(posedge clock) begin
      result_type predicted;
      result_type observed;
      if (reset) begin
         clear_state();
         awaited.delete();
         mismatches = 0;
         pixels_seen = 0;
         frames_done = 0;
         frames_failed = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == TIMEOUT_ADDR) begin
            if (csr_pwrite) begin
               timeout_setting = csr_pwdata[15:0];
            end else if (csr_prdata[15:0] != timeout_setting) begin
               report_mismatch("timeout_ms read-back", timeout_setting, csr_prdata[15:0]);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (predict_word(req_mon.action, req_mon.rx_byte, req_mon.packet_start,
                             predicted)) begin
               awaited.push_back(predicted);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.pixel_write = rsp_mon.pixel_write;
            observed.pixel_index = rsp_mon.pixel_index;
            observed.pixel_value = rsp_mon.pixel_value;
            observed.frame_done = rsp_mon.frame_done;
            observed.frame_failed = rsp_mon.frame_failed;
            observed.discard_count = rsp_mon.discard_count;
            if (observed.pixel_write) begin
               pixels_seen++;
            end
            if (observed.frame_done) begin
               frames_done++;
            end
            if (observed.frame_failed) begin
               frames_failed++;
            end
            compare_word(observed);
         end
      end
      words_awaited = awaited.size();
   end

endmodule

[tb/sv/thermal_packet_frame_assembler_core_test.sv]
// Top of the frame assembler testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps
module thermal_packet_frame_assembler_core_test;
   import tpfa_pkg::*;

   localparam int HALF_PERIOD_NS = 2;
   localparam int RESET_CYCLES = 12;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 600;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = CSR_ADDR_W'(4 * REG_TIMEOUT);
   localparam logic [7:0] LAST_PACKET = 8'(PACKETS_PER_SEGMENT_DEF - 1);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          mismatches;
   int          words_awaited;
   int          pixels_seen;
   int          frames_done;
   int          frames_failed;
   int          words_sent = 0;
   int          phase_words = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_go = 1'b0;

   tpfa_req_if req_chan ();
   tpfa_rsp_if rsp_chan ();

   always #(HALF_PERIOD_NS) clock = ~clock;

   thermal_packet_frame_assembler_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tpfa_pixel_compare pixel_compare (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .mismatches    (mismatches),
      .words_awaited (words_awaited),
      .pixels_seen   (pixels_seen),
      .frames_done   (frames_done),
      .frames_failed (frames_failed)
   );

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles without finishing.", cycle_count);
      $display("Some tests failed");
      $finish;
   end

   // The long hold-off lets the work queue fill so that the input side stalls.
   initial begin
      int  hold_left;
      bit  hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_word(input logic [1:0] act, input logic [7:0] b, input logic st,
                            input bit counted);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.rx_byte <= b;
      req_chan.packet_start <= st;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      if (counted) begin
         phase_words++;
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= TIMEOUT_ADDR;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_timeout(input logic [15:0] ms);
      drain_results();
      csr_access(1'b1, CSR_DATA_W'(ms));
      @(posedge clock);
      csr_access(1'b0, '0);
   endtask

   function automatic logic [7:0] packet_id(input logic [2:0] seg, input bit drop);
      logic [3:0] nibble;
      nibble = drop ? DROP_ID_NIBBLE : 4'($urandom_range(0, 14));
      return {1'($urandom), seg, nibble};
   endfunction

   task automatic send_packet(input logic [7:0] id_byte, input logic [7:0] number,
                              input int byte_count);
      int pick;
      send_word(ACT_BYTE, id_byte, 1'b1, 1'b1);
      for (int i = 1; i < byte_count; i++) begin
         pick = $urandom_range(0, 999);
         if (pick < 10) begin
            send_word(ACT_TICK, 8'($urandom), 1'($urandom), 1'b1);
         end else if (pick < 13) begin
            send_word(ACT_FAIL, 8'($urandom), 1'($urandom), 1'b1);
         end
         send_word(ACT_BYTE, (i == POS_NUMBER) ? number : 8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic send_loose_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_word(ACT_TICK, 8'($urandom), 1'($urandom), 1'b1);
      end else if (pick < 75) begin
         send_word(ACT_FAIL, 8'($urandom), 1'($urandom), 1'b1);
      end else if (pick < 88) begin
         send_word(ACT_UNUSED, 8'($urandom), 1'($urandom), 1'b0);
      end else begin
         send_word(ACT_BYTE, 8'($urandom), 1'b0, 1'b0);
      end
   endtask

   // A segment-setting packet, up to two unrelated packets, then the closing packet.
   task automatic send_segment_run();
      logic [2:0] seg;
      int         pick;
      pick = $urandom_range(0, 99);
      seg = (pick < 50) ? 3'd4 : (pick < 85) ? 3'($urandom_range(1, 3)) : 3'($urandom);
      send_packet(packet_id(seg, $urandom_range(0, 99) < 5), SEG_SET_PACKET,
                  ($urandom_range(0, 9) == 0) ? PACKET_BYTES_DEF : $urandom_range(2, 12));
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 3) == 0) begin
            send_loose_event();
         end
         send_packet(packet_id(3'($urandom), $urandom_range(0, 99) < 10),
                     8'($urandom_range(0, 63)), $urandom_range(1, 24));
      end
      send_packet(packet_id(3'($urandom), $urandom_range(0, 99) < 5),
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 63)) : LAST_PACKET,
                  ($urandom_range(0, 99) < 85) ? PACKET_BYTES_DEF : $urandom_range(2, 163));
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) send_word(ACT_BYTE, 8'($urandom), 1'b0, 1'b0);
      end
   endtask

   task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                            input int target);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      phase_words = 0;
      while (phase_words < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_loose_event();
         end else begin
            send_segment_run();
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action <= ACT_BYTE;
      req_chan.rx_byte <= '0;
      req_chan.packet_start <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0);

      // With a zero timeout every tick fails the capture at once.
      set_timeout(16'd0);
      send_word(ACT_TICK, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'hAA, 1'b0, 1'b0);
      send_word(ACT_UNUSED, 8'h55, 1'b1, 1'b0);
      send_word(ACT_FAIL, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h4F, 1'b1, 1'b1);
      send_word(ACT_BYTE, SEG_SET_PACKET, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h40, 1'b1, 1'b1);
      send_word(ACT_BYTE, 8'(PACKETS_PER_SEGMENT_DEF), 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h40, 1'b1, 1'b1);
      send_word(ACT_BYTE, SEG_SET_PACKET, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'hFF, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'hFF, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'hFF, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h70, 1'b1, 1'b1);
      send_word(ACT_BYTE, SEG_SET_PACKET, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h12, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h34, 1'b0, 1'b1);
      send_word(ACT_TICK, 8'hFF, 1'b1, 1'b1);
      send_word(ACT_BYTE, 8'h10, 1'b1, 1'b1);
      send_word(ACT_BYTE, 8'h05, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h00, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h01, 1'b0, 1'b1);
      send_word(ACT_BYTE, 8'h02, 1'b0, 1'b1);

      set_timeout(16'd1);
      run_phase(34, 60, PHASE_WORDS);
      set_timeout(16'($urandom_range(2, 12)));
      run_phase(60, 34, PHASE_WORDS);
      set_timeout(16'hFFFF);
      hold_go = 1'b1;
      run_phase(0, 0, PHASE_WORDS);

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      $display("Run covered %0d input words under three idling mixes and a long output stall:",
               words_sent);
      $display("%0d pixel words, %0d frames done, %0d timeouts.",
               pixels_seen, frames_done, frames_failed);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
